// ----- hw/rtl/itm_pkg.sv -----
// ----------------------------------------------------------------------------
// Instruction table match decoder package
// Shared sizes, item codes and the token that travels down the cell chain.
// ----------------------------------------------------------------------------
package itm_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SLOT_W      = 6;
   localparam int OP_W        = 7;
   localparam int F3_W        = 3;
   localparam int F7_W        = 7;
   localparam int WORD_W      = 32;
   localparam int LEVELS      = 3;
   localparam int CNT_W       = 2;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
   localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
   localparam logic [CNT_W-1:0] CNT_MANY = 2'd2;

   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [IDX_W-1:0] idx;
   } level_type;

   typedef struct packed {
      logic                   vld;
      logic                   kind;
      logic [SLOT_W-1:0]      slot;
      logic [OP_W-1:0]        op;
      logic [F3_W-1:0]        f3;
      logic [F7_W-1:0]        f7;
      level_type [LEVELS-1:0] lvl;
   } token_type;

endpackage

// ----- hw/rtl/instruction_table_match_decoder_top.sv -----
// ----------------------------------------------------------------------------
// Instruction table match decoder
// Loadable instruction table matched against RV32 words by a chain of cells.
// ----------------------------------------------------------------------------
// The request channel carries load and decode items. A load writes one table
// entry and produces no response; a decode produces one response transfer
// with found and the entry index of the single surviving entry.
// Each item enters a chain of TABLE_DEPTH cells, one cell per table entry,
// and moves one cell per cycle unless a stalled response holds the chain.
// A decode passes every cell stage, then the response register. One item
// may be accepted in every cycle while req_stall is low, so the chain holds
// up to TABLE_DEPTH items in flight; loads and decodes keep their order, as
// a load reaches its cell only after every earlier decode has passed it.
// Reset clears all entry valid marks and empties the chain and the response
// register. While a waiting response is stalled, the whole chain holds and
// the request side is stalled in the same cycle.
// ----------------------------------------------------------------------------
module instruction_table_match_decoder_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [itm_pkg::SLOT_W-1:0]    req_entry_slot,
   input  logic [itm_pkg::OP_W-1:0]      req_entry_opcode,
   input  logic [itm_pkg::F3_W-1:0]      req_entry_funct3,
   input  logic [itm_pkg::F7_W-1:0]      req_entry_funct7,
   input  logic [itm_pkg::WORD_W-1:0]    req_instruction_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [itm_pkg::SLOT_W-1:0]    rsp_entry_index
);

   itm_pkg::token_type chain [0:itm_pkg::TABLE_DEPTH];
   logic               advance;

   always_comb begin
      chain[0]      = '0;
      chain[0].vld  = req_valid;
      chain[0].kind = req_kind;
      chain[0].slot = req_entry_slot;
      if (req_kind == itm_pkg::KIND_DECODE) begin
         chain[0].op = req_instruction_word[6:0];
         chain[0].f3 = req_instruction_word[14:12];
         chain[0].f7 = req_instruction_word[31:25];
      end else begin
         chain[0].op = req_entry_opcode;
         chain[0].f3 = req_entry_funct3;
         chain[0].f7 = req_entry_funct7;
      end
   end

   assign req_stall = !advance;

   for (genvar i = 0; i < itm_pkg::TABLE_DEPTH; i++) begin : g_cell
      itm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (itm_pkg::IDX_W'(i)),
         .up_tok     (chain[i]),
         .down_tok   (chain[i+1])
      );
   end

   itm_resolve u_resolve (
      .clock           (clock),
      .reset           (reset),
      .tail_tok        (chain[itm_pkg::TABLE_DEPTH]),
      .rsp_stall       (rsp_stall),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_entry_index (rsp_entry_index)
   );

endmodule

// ----- hw/rtl/itm_cell.sv -----
// ----------------------------------------------------------------------------
// Instruction table match cell
// Holds one table entry and one token stage, and counts its matches into the
// token as the token passes.
// ----------------------------------------------------------------------------
module itm_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [itm_pkg::IDX_W-1:0] cell_index,
   input  itm_pkg::token_type       up_tok,
   output itm_pkg::token_type       down_tok
);

   logic [itm_pkg::OP_W-1:0] key_opcode_ff;
   logic [itm_pkg::F3_W-1:0] key_funct3_ff;
   logic [itm_pkg::F7_W-1:0] key_funct7_ff;
   logic                     slot_valid_ff;
   itm_pkg::token_type       stage_ff;
   itm_pkg::token_type       stage_in;
   logic                     slot_hit;
   logic                     load_hit;
   logic [itm_pkg::LEVELS-1:0] match;

   always_comb begin
      slot_hit = ({{itm_pkg::IDX_W{1'b0}}, up_tok.slot} ==
                  {{itm_pkg::SLOT_W{1'b0}}, cell_index});
      load_hit = up_tok.vld && (up_tok.kind == itm_pkg::KIND_LOAD) && slot_hit;
      match[0] = up_tok.vld && (up_tok.kind == itm_pkg::KIND_DECODE) && slot_valid_ff &&
                 (key_opcode_ff == up_tok.op);
      match[1] = match[0] && (key_funct3_ff == up_tok.f3);
      match[2] = match[1] && (key_funct7_ff == up_tok.f7);
   end

   always_comb begin
      stage_in = up_tok;
      for (int l = 0; l < itm_pkg::LEVELS; l++) begin
         if (match[l]) begin
            if (up_tok.lvl[l].cnt == itm_pkg::CNT_NONE) begin
               stage_in.lvl[l].idx = cell_index;
            end
            if (up_tok.lvl[l].cnt != itm_pkg::CNT_MANY) begin
               stage_in.lvl[l].cnt = up_tok.lvl[l].cnt + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_hit) begin
         key_opcode_ff <= up_tok.op;
         key_funct3_ff <= up_tok.f3;
         key_funct7_ff <= up_tok.f7;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else if (advance && load_hit) begin
         slot_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign down_tok = stage_ff;

`ifndef SYNTHESIS
   a_levels_nest : assert property (@(posedge clock) disable iff (reset)
      stage_ff.vld |-> (stage_ff.lvl[2].cnt <= stage_ff.lvl[1].cnt) &&
                       (stage_ff.lvl[1].cnt <= stage_ff.lvl[0].cnt))
      else $error("match count of a finer level exceeds a coarser one");

   a_load_marks : assert property (@(posedge clock) disable iff (reset)
      (advance && load_hit) |=> slot_valid_ff)
      else $error("loaded entry is not marked valid");

   a_empty_index : assert property (@(posedge clock) disable iff (reset)
      (stage_ff.vld && (stage_ff.lvl[0].cnt == itm_pkg::CNT_NONE)) |->
      (stage_ff.lvl[0].idx == '0))
      else $error("index recorded without a match");
`endif

endmodule

// ----- hw/rtl/itm_resolve.sv -----
// ----------------------------------------------------------------------------
// Instruction table match resolver
// Picks the unique survivor from the level counts of a finished token and
// holds the result transfer until it is taken.
// ----------------------------------------------------------------------------
module itm_resolve (
   input  logic                          clock,
   input  logic                          reset,
   input  itm_pkg::token_type            tail_tok,
   input  logic                          rsp_stall,
   output logic                          advance,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [itm_pkg::SLOT_W-1:0]    rsp_entry_index
);

   logic                                      rsp_valid_ff;
   logic                                      found_ff;
   logic                                      found_in;
   logic [itm_pkg::SLOT_W-1:0]                index_ff;
   logic [itm_pkg::SLOT_W-1:0]                index_in;
   logic [itm_pkg::IDX_W-1:0]                 pick;
   logic [itm_pkg::IDX_W+itm_pkg::SLOT_W-1:0] pick_wide;

   assign advance = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      found_in = 1'b0;
      pick     = '0;
      if (tail_tok.lvl[0].cnt == itm_pkg::CNT_ONE) begin
         found_in = 1'b1;
         pick     = tail_tok.lvl[0].idx;
      end else if (tail_tok.lvl[0].cnt == itm_pkg::CNT_MANY) begin
         if (tail_tok.lvl[1].cnt == itm_pkg::CNT_ONE) begin
            found_in = 1'b1;
            pick     = tail_tok.lvl[1].idx;
         end else if ((tail_tok.lvl[1].cnt == itm_pkg::CNT_MANY) &&
                      (tail_tok.lvl[2].cnt == itm_pkg::CNT_ONE)) begin
            found_in = 1'b1;
            pick     = tail_tok.lvl[2].idx;
         end
      end
      pick_wide = {{itm_pkg::SLOT_W{1'b0}}, pick};
      index_in  = pick_wide[itm_pkg::SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail_tok.vld && (tail_tok.kind == itm_pkg::KIND_DECODE);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         found_ff <= found_in;
         index_ff <= index_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_entry_index = index_ff;

endmodule
